@@ src/bamp_pkg.sv @@
package bamp_pkg;

    localparam int OPERAND_BITS = 8;
    localparam int VALUE_BITS   = 16;
    localparam int REM_BITS     = 8;
    localparam int CNT_W        = (OPERAND_BITS > 1) ? $clog2(OPERAND_BITS) : 1;
    localparam int ADD_W        = VALUE_BITS + 2;

    typedef enum logic [1:0] {
        OP_MUL    = 2'd0,
        OP_POPCNT = 2'd1,
        OP_DIV    = 2'd2,
        OP_POW    = 2'd3
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

endpackage

@@ src/byte_alu_mul_popcount_divmod_pow_core.sv @@
// Unsigned byte ALU: multiply, ones count, divide with remainder, power mod 2^16.
// Command channel: drive i_operation, i_operand_a, i_operand_b and raise start;
// the command transfers at a rising edge where start is high and busy is low.
// busy stays high while the command is worked on; nothing else is taken then.
// Result channel: o_value, o_remainder_out and o_status are shown for exactly
// one cycle with o_valid high. The receiver cannot stall; a result not taken in
// that cycle is gone. busy is low in the strobe cycle, so the next command can
// transfer there.
// Steps from transfer to strobe, done on one 16x16 multiplier and one adder
// used over and over under a step counter:
//   multiply            one pass through the multiplier
//   ones count          one bit per cycle through the adder, over OPERAND_BITS bits
//   divide              one restoring step per cycle, one per quotient bit
//   divide by zero      answered straight from idle, with no run state
//   power               multiply and square per exponent bit
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// command in flight; no result is issued for it.
module byte_alu_mul_popcount_divmod_pow_core
    import bamp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_operation,
    input  logic [OPERAND_BITS-1:0] i_operand_a,
    input  logic [OPERAND_BITS-1:0] i_operand_b,
    output logic                    o_valid,
    output logic [VALUE_BITS-1:0]   o_value,
    output logic [REM_BITS-1:0]     o_remainder_out,
    output logic                    o_status
);

    t_state                  r_state, n_state;
    t_op                     r_op, n_op;
    logic [OPERAND_BITS-1:0] r_a, n_a;
    logic [OPERAND_BITS-1:0] r_b, n_b;
    logic [OPERAND_BITS-1:0] r_rem, n_rem;
    logic [VALUE_BITS-1:0]   r_acc, n_acc;
    logic [VALUE_BITS-1:0]   r_sq, n_sq;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_phase, n_phase;
    logic                    r_valid, n_valid;
    logic [VALUE_BITS-1:0]   r_value, n_value;
    logic [REM_BITS-1:0]     r_rem_out, n_rem_out;
    logic                    r_status, n_status;

    // shared units
    logic [VALUE_BITS-1:0]   mul_x, mul_y;
    logic [2*VALUE_BITS-1:0] mul_p;
    logic [ADD_W-1:0]        add_x, add_y;
    logic                    add_inv, add_cin;
    logic [ADD_W:0]          add_sum;

    logic [OPERAND_BITS:0]   rem_sh;
    logic                    ge;
    logic [OPERAND_BITS-1:0] rem_next;
    logic [OPERAND_BITS-1:0] quo_next;
    logic                    last_bit;

    assign mul_p   = mul_x * mul_y;
    assign add_sum = {1'b0, add_x} + {1'b0, (add_inv ? ~add_y : add_y)}
                     + (ADD_W+1)'(add_cin);

    assign rem_sh   = {r_rem, r_a[OPERAND_BITS-1]};
    assign ge       = add_sum[ADD_W];
    assign rem_next = ge ? add_sum[OPERAND_BITS-1:0] : rem_sh[OPERAND_BITS-1:0];
    assign quo_next = {r_a[OPERAND_BITS-2:0], ge};
    assign last_bit = (r_cnt == CNT_W'(OPERAND_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_a       <= n_a;
        r_b       <= n_b;
        r_rem     <= n_rem;
        r_acc     <= n_acc;
        r_sq      <= n_sq;
        r_cnt     <= n_cnt;
        r_phase   <= n_phase;
        r_value   <= n_value;
        r_rem_out <= n_rem_out;
        r_status  <= n_status;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_a       = r_a;
        n_b       = r_b;
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_sq      = r_sq;
        n_cnt     = r_cnt;
        n_phase   = r_phase;
        n_valid   = 1'b0;
        n_value   = r_value;
        n_rem_out = r_rem_out;
        n_status  = r_status;

        mul_x   = VALUE_BITS'(r_a);
        mul_y   = VALUE_BITS'(r_b);
        add_x   = ADD_W'(r_acc);
        add_y   = '0;
        add_inv = 1'b0;
        add_cin = r_a[r_cnt];

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op    = t_op'(i_operation);
                    n_a     = i_operand_a;
                    n_b     = i_operand_b;
                    n_rem   = '0;
                    n_acc   = (t_op'(i_operation) == OP_POW) ? VALUE_BITS'(1) : '0;
                    n_sq    = VALUE_BITS'(i_operand_a);
                    n_cnt   = '0;
                    n_phase = 1'b0;
                    if (t_op'(i_operation) == OP_DIV && i_operand_b == '0) begin
                        // divide by zero: answer at once
                        n_valid   = 1'b1;
                        n_value   = '0;
                        n_rem_out = '0;
                        n_status  = 1'b1;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                case (r_op)
                    OP_MUL: begin
                        n_valid   = 1'b1;
                        n_value   = mul_p[VALUE_BITS-1:0];
                        n_rem_out = '0;
                        n_status  = 1'b0;
                        n_state   = ST_IDLE;
                    end
                    OP_POPCNT: begin
                        n_acc = add_sum[VALUE_BITS-1:0];
                        n_cnt = r_cnt + CNT_W'(1);
                        if (last_bit) begin
                            n_valid   = 1'b1;
                            n_value   = add_sum[VALUE_BITS-1:0];
                            n_rem_out = '0;
                            n_status  = 1'b0;
                            n_state   = ST_IDLE;
                        end
                    end
                    OP_DIV: begin
                        // restoring step: trial subtract of the divisor
                        add_x   = ADD_W'(rem_sh);
                        add_y   = ADD_W'(r_b);
                        add_inv = 1'b1;
                        add_cin = 1'b1;
                        n_rem   = rem_next;
                        n_a     = quo_next;
                        n_cnt   = r_cnt + CNT_W'(1);
                        if (last_bit) begin
                            n_valid   = 1'b1;
                            n_value   = VALUE_BITS'(quo_next);
                            n_rem_out = REM_BITS'(rem_next);
                            n_status  = 1'b0;
                            n_state   = ST_IDLE;
                        end
                    end
                    default: begin
                        // power: phase 0 folds in the square, phase 1 squares
                        if (!r_phase) begin
                            mul_x = r_acc;
                            mul_y = r_sq;
                            if (r_b[r_cnt]) begin
                                n_acc = mul_p[VALUE_BITS-1:0];
                            end
                            n_phase = 1'b1;
                        end else begin
                            mul_x   = r_sq;
                            mul_y   = r_sq;
                            n_sq    = mul_p[VALUE_BITS-1:0];
                            n_phase = 1'b0;
                            n_cnt   = r_cnt + CNT_W'(1);
                            if (last_bit) begin
                                n_valid   = 1'b1;
                                n_value   = r_acc;
                                n_rem_out = '0;
                                n_status  = 1'b0;
                                n_state   = ST_IDLE;
                            end
                        end
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_value         = r_value;
    assign o_remainder_out = r_rem_out;
    assign o_status        = r_status;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation != OP_DIV || i_operand_b != '0)) |=> busy)
        else $error("accepted command did not raise busy");

    a_div_zero_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_DIV && i_operand_b == '0)
        |=> (o_valid && o_status && !busy))
        else $error("divide by zero not answered at once");

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_value == '0 && o_remainder_out == '0))
        else $error("divide by zero result not zero");

    a_mul_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_op == OP_MUL) |=> (o_valid && !busy))
        else $error("multiply result late");

endmodule
